>>> design/sprite_screen_projection_core_assert.svh
// Assertion macros, clocked on clk and disabled while rst is high.
`ifndef SPRITE_SCREEN_PROJECTION_CORE_ASSERT_SVH
`define SPRITE_SCREEN_PROJECTION_CORE_ASSERT_SVH

// pre holds -> post holds in the same cycle
`define SSP_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed: same-cycle implication");

// pre holds -> post holds in the next cycle
`define SSP_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> design/ssp_pkg.sv
package ssp_pkg;

  localparam int FRAC_BITS  = 16;

  localparam int IDX_W      = 8;
  localparam int POS_W      = 24;
  localparam int VEC_W      = 18;
  localparam int DIM_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int DIFF_W     = POS_W + 1;
  localparam int DPROD_W    = 2 * VEC_W;
  localparam int NPROD_W    = VEC_W + DIFF_W;
  localparam int DET_W      = DPROD_W + 1;
  localparam int NUM_W      = NPROD_W + 1;
  localparam int SUM_W      = NUM_W + 1;

  localparam int DIV_VW     = NUM_W;
  localparam int DIV_NW     = (NUM_W - 1 + FRAC_BITS > 58) ? (NUM_W - 1 + FRAC_BITS) : 58;
  localparam int EXT_W      = DIV_NW + 2;

  localparam int COL_W      = 16;
  localparam int SIZE_W     = 16;
  localparam int SX_W       = 15;
  localparam int EX_W       = 16;
  localparam int SY_W       = 12;
  localparam int EY_W       = 12;
  localparam int DEPTH_W    = 24;

  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_DIR_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_DIR_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_PLANE_X   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_PLANE_Y   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd7;

  localparam logic [VEC_W-1:0] ONE_Q2   = VEC_W'(1 << FRAC_BITS);
  localparam logic [VEC_W-1:0] PLANE_Q2 = VEC_W'(43254);
  localparam logic [DIM_W-1:0] W_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] H_RESET  = DIM_W'(480);

  localparam logic [DIV_NW-1:0] DEPTH_POS_MAX = DIV_NW'((1 << (DEPTH_W - 1)) - 1);
  localparam logic [DIV_NW-1:0] DEPTH_NEG_MAX = DIV_NW'(1 << (DEPTH_W - 1));

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             degen;
    logic             pos;
    logic             col_neg;
  } side_t;

endpackage

>>> design/ssp_if.sv
interface ssp_in_if;
  logic                             valid;
  logic                             ready;
  logic [ssp_pkg::IDX_W-1:0]        sprite_index;
  logic signed [ssp_pkg::POS_W-1:0] sprite_x;
  logic signed [ssp_pkg::POS_W-1:0] sprite_y;
  modport source (output valid, sprite_index, sprite_x, sprite_y, input ready);
  modport sink (input valid, sprite_index, sprite_x, sprite_y, output ready);
endinterface

interface ssp_out_if;
  logic                               valid;
  logic                               ready;
  logic [ssp_pkg::IDX_W-1:0]          index_out;
  logic signed [ssp_pkg::COL_W-1:0]   column_center;
  logic [ssp_pkg::SIZE_W-1:0]         sprite_size;
  logic [ssp_pkg::SX_W-1:0]           start_x;
  logic signed [ssp_pkg::EX_W-1:0]    end_x;
  logic [ssp_pkg::SY_W-1:0]           start_y;
  logic [ssp_pkg::EY_W-1:0]           end_y;
  logic signed [ssp_pkg::DEPTH_W-1:0] depth;
  logic                               in_front;
  logic                               degenerate;
  modport source (output valid, index_out, column_center, sprite_size, start_x, end_x,
                  start_y, end_y, depth, in_front, degenerate, input ready);
  modport sink (input valid, index_out, column_center, sprite_size, start_x, end_x,
                start_y, end_y, depth, in_front, degenerate, output ready);
endinterface

interface ssp_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ssp_pkg::CFG_IDX_W-1:0]    index;
  logic [ssp_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/sprite_screen_projection_core.sv
// Projects one sprite per clock into screen space. A new request can be taken
// every cycle unless the pipeline stalls; the three radix-2 dividers
// (column, size, depth) each resolve one quotient bit per stage. While the
// result register is held, the pipeline stalls but still takes one request into
// its input stage. Configuration writes are taken at any time and should only
// be issued while no sprite is in flight.
`include "sprite_screen_projection_core_assert.svh"

module sprite_screen_projection_core (
  input logic clk,
  input logic rst,
  ssp_in_if.sink    sprite,
  ssp_out_if.source result,
  ssp_cfg_if.sink   cfg
);
  import ssp_pkg::*;

  logic signed [POS_W-1:0] camera_x, camera_y;
  logic signed [VEC_W-1:0] view_dir_x, view_dir_y, cam_plane_x, cam_plane_y;
  logic [DIM_W-1:0]        screen_width, screen_height;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_x      <= '0;
      camera_y      <= '0;
      view_dir_x    <= ONE_Q2;
      view_dir_y    <= '0;
      cam_plane_x   <= '0;
      cam_plane_y   <= PLANE_Q2;
      screen_width  <= W_RESET;
      screen_height <= H_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_CAMERA_X:      camera_x      <= cfg.data[POS_W-1:0];
        REG_CAMERA_Y:      camera_y      <= cfg.data[POS_W-1:0];
        REG_VIEW_DIR_X:    view_dir_x    <= cfg.data[VEC_W-1:0];
        REG_VIEW_DIR_Y:    view_dir_y    <= cfg.data[VEC_W-1:0];
        REG_CAM_PLANE_X:   cam_plane_x   <= cfg.data[VEC_W-1:0];
        REG_CAM_PLANE_Y:   cam_plane_y   <= cfg.data[VEC_W-1:0];
        REG_SCREEN_WIDTH:  screen_width  <= cfg.data[DIM_W-1:0];
        REG_SCREEN_HEIGHT: screen_height <= cfg.data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 0: input register
  logic                    v0;
  logic [IDX_W-1:0]        idx0;
  logic signed [POS_W-1:0] spx0, spy0;

  logic en, ld0;
  assign en           = !result.valid || result.ready;
  assign ld0          = en || !v0;
  assign sprite.ready = ld0;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (ld0) v0 <= sprite.valid;
  end
  always_ff @(posedge clk) begin
    if (ld0) begin
      idx0 <= sprite.sprite_index;
      spx0 <= sprite.sprite_x;
      spy0 <= sprite.sprite_y;
    end
  end

  logic v1, v2, v3, v4, v5, v6, ve;
  logic [IDX_W-1:0] idx1, idx2, idx3, idx4;
  logic signed [DIFF_W-1:0]  dx1, dy1;
  logic signed [DPROD_W-1:0] pd_a2, pd_b2;
  logic signed [NPROD_W-1:0] px_a2, px_b2, py_a2, py_b2;
  logic signed [DET_W-1:0]   det3;
  logic signed [NUM_W-1:0]   numx3, numy3;
  logic signed [SUM_W-1:0]   sum4;
  logic [DIV_VW-1:0]         det_mag4, numy_mag4, det_mag5, numy_mag5;
  logic                      degen4, pos4, numy_neg4;
  logic [SUM_W-1:0]          sum_mag5;
  side_t                     side5, side6, side_e;
  logic [DIV_NW-1:0]         colnum6, sizenum6, depthnum6;
  logic [DIV_VW-1:0]         colden6, depthden6;
  logic [DIV_NW-1:0]         colnum_c, sizenum_c, depthnum_c;
  logic [DIV_NW-1:0]         colq, sizeq, depthq;

  assign colnum_c   = {{(DIV_NW - DIM_W + 1){1'b0}}, screen_width[DIM_W-1:1]} *
                      {{(DIV_NW - SUM_W){1'b0}}, sum_mag5};
  assign sizenum_c  = {{(DIV_NW - DIM_W){1'b0}}, screen_height} *
                      {{(DIV_NW - DIV_VW){1'b0}}, det_mag5};
  assign depthnum_c = {{(DIV_NW - DIV_VW){1'b0}}, numy_mag5} << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx1 <= idx0;
      dx1  <= {spx0[POS_W-1], spx0} - {camera_x[POS_W-1], camera_x};
      dy1  <= {spy0[POS_W-1], spy0} - {camera_y[POS_W-1], camera_y};

      idx2  <= idx1;
      pd_a2 <= cam_plane_x * view_dir_y;
      pd_b2 <= view_dir_x * cam_plane_y;
      px_a2 <= view_dir_y * dx1;
      px_b2 <= view_dir_x * dy1;
      py_a2 <= cam_plane_x * dy1;
      py_b2 <= cam_plane_y * dx1;

      idx3  <= idx2;
      det3  <= DET_W'(pd_a2) - DET_W'(pd_b2);
      numx3 <= NUM_W'(px_a2) - NUM_W'(px_b2);
      numy3 <= NUM_W'(py_a2) - NUM_W'(py_b2);

      idx4      <= idx3;
      sum4      <= SUM_W'(numx3) + SUM_W'(numy3);
      det_mag4  <= det3[DET_W-1] ? DIV_VW'(-det3) : DIV_VW'(det3);
      numy_mag4 <= numy3[NUM_W-1] ? DIV_VW'(-numy3) : DIV_VW'(numy3);
      degen4    <= (det3 == '0) || (numy3 == '0);
      pos4      <= (numy3 > 0) == (det3 > 0);
      numy_neg4 <= numy3[NUM_W-1];

      side5.index   <= idx4;
      side5.degen   <= degen4;
      side5.pos     <= pos4;
      side5.col_neg <= sum4[SUM_W-1] ^ numy_neg4;
      sum_mag5      <= sum4[SUM_W-1] ? SUM_W'(-sum4) : SUM_W'(sum4);
      det_mag5      <= det_mag4;
      numy_mag5     <= numy_mag4;

      side6     <= side5;
      colnum6   <= colnum_c;
      sizenum6  <= sizenum_c;
      depthnum6 <= depthnum_c;
      colden6   <= numy_mag5;
      depthden6 <= det_mag5;
    end
  end

  ssp_div u_div_col (
    .clk (clk), .en (en), .num (colnum6), .den (colden6), .quo (colq)
  );
  ssp_div u_div_size (
    .clk (clk), .en (en), .num (sizenum6), .den (colden6), .quo (sizeq)
  );
  ssp_div u_div_depth (
    .clk (clk), .en (en), .num (depthnum6), .den (depthden6), .quo (depthq)
  );

  // sideband travels alongside the divider stages
  logic [DIV_NW-1:0] v_div;
  side_t             side_d [DIV_NW];

  always_ff @(posedge clk) begin
    if (rst) v_div <= '0;
    else if (en) v_div <= {v_div[DIV_NW-2:0], v6};
  end
  always_ff @(posedge clk) begin
    if (en) begin
      side_d[0] <= side6;
      for (int i = 1; i < DIV_NW; i++) side_d[i] <= side_d[i-1];
    end
  end

  // stage E: signs and depth saturation
  logic signed [DIV_NW:0]    col_e;
  logic [DIV_NW-1:0]         size_e;
  logic signed [DEPTH_W-1:0] depth_e;

  always_ff @(posedge clk) begin
    if (rst) ve <= 1'b0;
    else if (en) ve <= v_div[DIV_NW-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      side_e <= side_d[DIV_NW-1];
      col_e  <= side_d[DIV_NW-1].col_neg ? -$signed({1'b0, colq}) : $signed({1'b0, colq});
      size_e <= sizeq;
      if (side_d[DIV_NW-1].pos) begin
        depth_e <= (depthq > DEPTH_POS_MAX) ? DEPTH_POS_MAX[DEPTH_W-1:0]
                                            : depthq[DEPTH_W-1:0];
      end else begin
        depth_e <= (depthq > DEPTH_NEG_MAX) ? DEPTH_NEG_MAX[DEPTH_W-1:0]
                                            : DEPTH_W'(-depthq);
      end
    end
  end

  // stage F: bounds, clamps and degenerate zeroing into the result register
  logic signed [EXT_W-1:0] col_x, half_x, w_half_x, h_half_x, w_m1_x, h_m1_x;
  logic signed [EXT_W-1:0] sx_c, ex_c, sy_c, ey_c, ex_l, ey_l;

  always_comb begin
    col_x    = EXT_W'(col_e);
    half_x   = $signed({2'b00, 1'b0, size_e[DIV_NW-1:1]});
    w_half_x = $signed({{(EXT_W - DIM_W + 1){1'b0}}, screen_width[DIM_W-1:1]});
    h_half_x = $signed({{(EXT_W - DIM_W + 1){1'b0}}, screen_height[DIM_W-1:1]});
    w_m1_x   = $signed({{(EXT_W - DIM_W){1'b0}}, screen_width}) - EXT_W'(1);
    h_m1_x   = $signed({{(EXT_W - DIM_W){1'b0}}, screen_height}) - EXT_W'(1);
    sx_c     = col_x - half_x;
    ex_c     = col_x + half_x;
    sy_c     = h_half_x - half_x;
    ey_c     = half_x + h_half_x;
    ex_l     = (ex_c > w_m1_x) ? w_m1_x : ex_c;
    ey_l     = (ey_c > h_m1_x) ? h_m1_x : ey_c;
  end

  always_ff @(posedge clk) begin
    if (rst) result.valid <= 1'b0;
    else if (en) result.valid <= ve;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.index_out  <= side_e.index;
      result.degenerate <= side_e.degen;
      if (side_e.degen) begin
        result.column_center <= '0;
        result.sprite_size   <= '0;
        result.start_x       <= '0;
        result.end_x         <= '0;
        result.start_y       <= '0;
        result.end_y         <= '0;
        result.depth         <= '0;
        result.in_front      <= 1'b0;
      end else begin
        result.column_center <= (col_x > 32767) ? COL_W'(32767) :
                                (col_x < -32768) ? COL_W'(-32768) : col_x[COL_W-1:0];
        result.sprite_size   <= (size_e > DIV_NW'(65535)) ? SIZE_W'(65535)
                                                          : size_e[SIZE_W-1:0];
        result.start_x       <= (sx_c < 0) ? SX_W'(0) :
                                (sx_c > 32767) ? SX_W'(32767) : sx_c[SX_W-1:0];
        result.end_x         <= (ex_l < -32768) ? EX_W'(-32768) :
                                (ex_l > 32767) ? EX_W'(32767) : ex_l[EX_W-1:0];
        result.start_y       <= (sy_c < 0) ? SY_W'(0) :
                                (sy_c > 4095) ? SY_W'(4095) : sy_c[SY_W-1:0];
        result.end_y         <= (ey_l < 0) ? EY_W'(0) :
                                (ey_l > 4095) ? EY_W'(4095) : ey_l[EY_W-1:0];
        result.depth         <= depth_e;
        result.in_front      <= side_e.pos;
      end
    end
  end

  `SSP_ASSERT_SAME(a_degen_zero, result.valid && result.degenerate,
                   result.sprite_size == '0 && !result.in_front && result.depth == '0)
  `SSP_ASSERT_SAME(a_front_sign, result.valid && result.in_front, !result.depth[DEPTH_W-1])
  `SSP_ASSERT_SAME(a_stall_gate, !en && v0, !sprite.ready)
  `SSP_ASSERT_NEXT(a_hold_stage0, !en && v0, v0 && $stable(idx0))

endmodule

>>> design/ssp_div.sv
module ssp_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [ssp_pkg::DIV_NW-1:0]   num,
  input  logic [ssp_pkg::DIV_VW-1:0]   den,
  output logic [ssp_pkg::DIV_NW-1:0]   quo
);
  import ssp_pkg::*;

  // one restoring step per stage, MSB first; quotient bits shift in as
  // dividend bits shift out
  logic [DIV_VW-1:0] rem [DIV_NW];
  logic [DIV_NW-1:0] nq  [DIV_NW];
  logic [DIV_VW-1:0] dv  [DIV_NW];

  for (genvar i = 0; i < DIV_NW; i++) begin : g_stage
    logic [DIV_VW-1:0] rem_in;
    logic [DIV_NW-1:0] nq_in;
    logic [DIV_VW-1:0] dv_in;
    logic [DIV_VW:0]   trial;
    logic [DIV_VW:0]   diff;
    logic              ge;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num;
      assign dv_in  = den;
    end else begin : g_rest
      assign rem_in = rem[i-1];
      assign nq_in  = nq[i-1];
      assign dv_in  = dv[i-1];
    end

    assign trial = {rem_in, nq_in[DIV_NW-1]};
    assign diff  = trial - {1'b0, dv_in};
    assign ge    = trial >= {1'b0, dv_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= ge ? diff[DIV_VW-1:0] : trial[DIV_VW-1:0];
        nq[i]  <= {nq_in[DIV_NW-2:0], ge};
        dv[i]  <= dv_in;
      end
    end
  end

  assign quo = nq[DIV_NW-1];

endmodule
